[rtl/awfe_pkg.sv]
// Package for the article wire-format encoder: character codes, the terminator
// pattern and the types passed between the front end, the queue and the back end.
// No dependencies.
package awfe_pkg;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_DOT = 8'h2E;

	// CR LF '.' CR LF, with the newest byte in the low byte.
	localparam logic [39:0] TERM_PATTERN = 40'h0D_0A_2E_0D_0A;

	// An item expands to at most seven output bytes.
	localparam int unsigned MAX_BYTES = 7;
	localparam logic [2:0] TAIL_FULL = 3'd5;

	// One classified item: its output bytes in order and how many there are.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                cnt;
		logic                      last;
	} desc_t;

	// Queue status, used by the top level.
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Back-end sequencer status.
	typedef struct packed {
		logic mid_item;
		logic adv;
		logic adv_final;
	} back_stat_t;

endpackage

[rtl/awfe_front.sv]
// Front end of the article wire-format encoder: accepts input transactions,
// tracks line and tail state, and builds one output descriptor per item.
// Depends on awfe_pkg.
module awfe_front import awfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wire_mode_we,
	input  logic       wire_mode_wdata,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       byte_valid,
	input  logic       end_of_article,
	output logic       desc_push,
	output desc_t      desc
);

	logic        wire_mode_q;
	logic        line_ended_q;
	logic        prev_was_cr_q;
	logic [39:0] tail_q;
	logic [2:0]  tail_cnt_q;

	logic        line_ended_n;
	logic        prev_was_cr_n;
	logic [39:0] tail_n;
	logic [39:0] tail_end;
	logic [2:0]  tail_cnt_n;
	logic [1:0]  dn;
	logic [7:0]  d0;
	logic [7:0]  d1;
	logic [2:0]  en;
	logic [4:0][7:0] ext;
	logic        add_crlf;
	logic        add_term;
	logic [3:0]  total;
	logic [2:0]  sel;

	// Data part of the item: conversion, stuffing and wire-mode line tracking.
	always_comb begin
		dn            = 2'd0;
		d0            = data_byte;
		d1            = data_byte;
		line_ended_n  = line_ended_q;
		prev_was_cr_n = prev_was_cr_q;
		if (byte_valid) begin
			if (wire_mode_q) begin
				dn           = 2'd1;
				line_ended_n = prev_was_cr_q && (data_byte == CH_LF);
			end else if (data_byte == CH_LF) begin
				dn           = 2'd2;
				d0           = CH_CR;
				d1           = CH_LF;
				line_ended_n = 1'b1;
			end else if (line_ended_q && (data_byte == CH_DOT)) begin
				dn           = 2'd2;
				d0           = CH_DOT;
				line_ended_n = 1'b0;
			end else begin
				dn           = 2'd1;
				line_ended_n = 1'b0;
			end
			prev_was_cr_n = (data_byte == CH_CR);
		end
	end

	// Tail window of the last five data-driven output bytes and its fill count.
	always_comb begin
		case (dn)
			2'd1:    tail_n = {tail_q[31:0], d0};
			2'd2:    tail_n = {tail_q[23:0], d0, d1};
			default: tail_n = tail_q;
		endcase
		if ((tail_cnt_q + {1'b0, dn}) > TAIL_FULL) begin
			tail_cnt_n = TAIL_FULL;
		end else begin
			tail_cnt_n = tail_cnt_q + {1'b0, dn};
		end
	end

	// Closing bytes for the final item of an article. The terminator check sees
	// the tail after any appended CR LF.
	always_comb begin
		add_crlf = end_of_article && !line_ended_n;
		tail_end = add_crlf ? {tail_n[23:0], CH_CR, CH_LF} : tail_n;
		add_term = end_of_article && (!wire_mode_q || (tail_cnt_n < TAIL_FULL) ||
			(tail_end != TERM_PATTERN));
		ext = '0;
		en  = 3'd0;
		if (add_crlf && add_term) begin
			ext = {CH_LF, CH_CR, CH_DOT, CH_LF, CH_CR};
			en  = 3'd5;
		end else if (add_crlf) begin
			ext = {24'h0, CH_LF, CH_CR};
			en  = 3'd2;
		end else if (add_term) begin
			ext = {16'h0, CH_LF, CH_CR, CH_DOT};
			en  = 3'd3;
		end
	end

	// Pack data bytes followed by closing bytes into the descriptor.
	always_comb begin
		total     = {2'b00, dn} + {1'b0, en};
		desc.cnt  = total[2:0];
		desc.last = end_of_article;
		for (int i = 0; i < MAX_BYTES; i++) begin
			sel = 3'(i) - {1'b0, dn};
			if (3'(i) < {1'b0, dn}) begin
				desc.bytes[i] = (i == 0) ? d0 : d1;
			end else if (sel < 3'd5) begin
				desc.bytes[i] = ext[sel];
			end else begin
				desc.bytes[i] = 8'h00;
			end
		end
		desc_push = accept && (total != 4'd0);
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wire_mode_q <= 1'b0;
		end else if (wire_mode_we) begin
			wire_mode_q <= wire_mode_wdata;
		end
	end

	// Article state, cleared after each final item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_ended_q  <= 1'b0;
			prev_was_cr_q <= 1'b0;
			tail_q        <= '0;
			tail_cnt_q    <= '0;
		end else if (accept) begin
			if (end_of_article) begin
				line_ended_q  <= 1'b0;
				prev_was_cr_q <= 1'b0;
				tail_q        <= '0;
				tail_cnt_q    <= '0;
			end else begin
				line_ended_q  <= line_ended_n;
				prev_was_cr_q <= prev_was_cr_n;
				tail_q        <= tail_n;
				tail_cnt_q    <= tail_cnt_n;
			end
		end
	end

endmodule

[rtl/awfe_fifo.sv]
// Descriptor queue between the front end and the back end of the encoder.
// Depends on awfe_pkg.
module awfe_fifo import awfe_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr,
	input  desc_t      wr_data,
	input  logic       rd,
	output desc_t      rd_data,
	output fifo_stat_t stat
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	desc_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_data    = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/awfe_back.sv]
// Back end of the encoder: walks each descriptor one byte per cycle into the
// output register while it is free or draining. Depends on awfe_pkg.
module awfe_back import awfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  desc_t      desc,
	input  logic       desc_avail,
	output logic       desc_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       out_last,
	output back_stat_t stat
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       adv;
	logic       final_byte;

	// Advance when a descriptor waits and the output register is free or draining.
	always_comb begin
		adv           = desc_avail && (!out_valid_q || pop);
		final_byte    = (idx_q == (desc.cnt - 3'd1));
		desc_pop      = adv && final_byte;
		stat.mid_item = (idx_q != 3'd0);
		stat.adv      = adv;
		stat.adv_final = desc_pop;
	end

	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

	// Byte index within the head descriptor and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				idx_q       <= final_byte ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= desc.bytes[idx_q];
			out_last_q <= desc.last && final_byte;
		end
	end

endmodule

[rtl/article_wire_format_encoder_unit.sv]
// Top level of the article wire-format encoder: front end, descriptor queue
// and back end. Depends on awfe_pkg, awfe_front, awfe_fifo and awfe_back.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------------
//  input   | in        | push / full       | data_byte, byte_valid, end_of_article
//  result  | out       | pop / empty       | out_byte, out_last
//  config  | in        | wire_mode_we      | wire_mode_wdata
//
// Each item yields zero to seven output bytes (one for a plain byte, two for a
// converted LF or stuffed dot, up to seven); the back end delivers one byte
// per cycle while the output register is free or being popped.
// An accepted item passes through the descriptor queue and then the output
// register before its first byte is on the result ports.
// full rises only when the QUEUE_DEPTH-entry descriptor queue is full; the
// output register frees as soon as pop takes a transaction. Reset clears all
// state but the queue storage and output payload, and sets wire_mode to local text.
module article_wire_format_encoder_unit import awfe_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wire_mode_we,
	input  logic       wire_mode_wdata,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       byte_valid,
	input  logic       end_of_article,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       out_last
);

	desc_t      wr_desc;
	desc_t      head_desc;
	logic       desc_push;
	logic       desc_pop;
	fifo_stat_t q_stat;
	back_stat_t b_stat;
	logic       accept;

	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;

	// Classification of input transactions.
	awfe_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.wire_mode_we    (wire_mode_we),
		.wire_mode_wdata (wire_mode_wdata),
		.accept          (accept),
		.data_byte       (data_byte),
		.byte_valid      (byte_valid),
		.end_of_article  (end_of_article),
		.desc_push       (desc_push),
		.desc            (wr_desc)
	);

	// Decoupling queue.
	awfe_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (desc_push),
		.wr_data (wr_desc),
		.rd      (desc_pop),
		.rd_data (head_desc),
		.stat    (q_stat)
	);

	// Byte sequencer and result register.
	awfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc       (head_desc),
		.desc_avail (!q_stat.empty),
		.desc_pop   (desc_pop),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.stat       (b_stat)
	);

	// The queue can never report full and empty together.
	a_queue_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("descriptor queue both full and empty");

	// Finishing a descriptor returns the sequencer to the first byte.
	a_item_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		b_stat.adv_final |=> !b_stat.mid_item)
		else $error("byte index did not wrap after a descriptor");

	// The sequencer only sits mid-descriptor while that descriptor is still queued.
	a_mid_has_desc: assert property (@(posedge clk) disable iff (!arst_n)
		b_stat.mid_item |-> !q_stat.empty)
		else $error("sequencer mid-item with no descriptor queued");

	// A result is loaded into the output register whenever the sequencer advances.
	a_adv_loads: assert property (@(posedge clk) disable iff (!arst_n)
		b_stat.adv |=> !empty)
		else $error("output register empty after an advance");

endmodule

[bench/tb_top.sv]
// Self-checking bench for the article wire-format encoder: directed and random
// articles in both modes, results compared byte by byte with an encoding model.
// Depends on awfe_pkg and article_wire_format_encoder_unit.
module tb_top;
	import awfe_pkg::*;

	localparam bit MODE_LOCAL = 1'b0;
	localparam bit MODE_WIRE  = 1'b1;
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD = 300;
	localparam int RUN_LIMIT = 400000;

	// One input transaction and one result transaction.
	typedef struct {
		logic [7:0] data;
		logic       valid;
		logic       eoa;
	} article_item_t;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} wire_byte_t;

	logic       clk;
	logic       arst_n;
	logic       wire_mode_we;
	logic       wire_mode_wdata;
	logic       push;
	logic       full;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       end_of_article;
	logic       empty;
	logic       pop;
	logic [7:0] out_byte;
	logic       out_last;

	article_item_t pending_items[$];
	wire_byte_t    wire_bytes_due[$];

	// Encoder state as the bench predicts it.
	logic        enc_wire_mode;
	logic        enc_line_ended;
	logic        enc_after_cr;
	logic [39:0] enc_tail;
	logic [2:0]  enc_tail_cnt;

	logic in_taken;
	int   gap_left;
	int   burst_left;
	bit   sender_steady;
	logic [31:0] stall_pat;
	int   pat_left;
	int   hold_left;
	int   hold_requests;
	int   hold_served;
	int   items_queued;
	int   errors;

	article_wire_format_encoder_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.wire_mode_we   (wire_mode_we),
		.wire_mode_wdata(wire_mode_wdata),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.end_of_article (end_of_article),
		.empty          (empty),
		.pop            (pop),
		.out_byte       (out_byte),
		.out_last       (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#RUN_LIMIT;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch: %s got %0h expected %0h", what, got, want);
		errors++;
	endtask

	// Appends one predicted output byte and shifts it into the tail window.
	task automatic emit_byte(input logic [7:0] b, inout int n);
		wire_byte_t wb;
		wb.value = b;
		wb.last = 1'b0;
		wire_bytes_due.push_back(wb);
		enc_tail = {enc_tail[31:0], b};
		n++;
	endtask

	// Works out the output bytes that one accepted transaction causes.
	task automatic encode_item(input logic [7:0] b, input logic v, input logic eoa);
		int n;
		bit short_art;
		wire_byte_t wb;
		n = 0;
		if (v) begin
			if (enc_wire_mode == MODE_WIRE) begin
				enc_line_ended = enc_after_cr && (b == CH_LF);
				emit_byte(b, n);
			end else if (b == CH_LF) begin
				emit_byte(CH_CR, n);
				emit_byte(CH_LF, n);
				enc_line_ended = 1'b1;
			end else begin
				if (enc_line_ended && b == CH_DOT)
					emit_byte(CH_DOT, n);
				enc_line_ended = 1'b0;
				emit_byte(b, n);
			end
			enc_after_cr = (b == CH_CR);
			if (int'(enc_tail_cnt) + n >= 5)
				enc_tail_cnt = 3'd5;
			else
				enc_tail_cnt = enc_tail_cnt + 3'(n);
		end
		if (eoa) begin
			short_art = (enc_tail_cnt < 3'd5);
			if (!enc_line_ended) begin
				emit_byte(CH_CR, n);
				emit_byte(CH_LF, n);
			end
			if (enc_wire_mode != MODE_WIRE || short_art || enc_tail != TERM_PATTERN) begin
				emit_byte(CH_DOT, n);
				emit_byte(CH_CR, n);
				emit_byte(CH_LF, n);
			end
			if (n > 0) begin
				wb = wire_bytes_due[wire_bytes_due.size() - 1];
				wb.last = 1'b1;
				wire_bytes_due[wire_bytes_due.size() - 1] = wb;
			end
			enc_line_ended = 1'b0;
			enc_after_cr = 1'b0;
			enc_tail = '0;
			enc_tail_cnt = '0;
		end
	endtask

	// Prediction at acceptance, config tracking and result checking.
	always @(posedge clk) begin
		wire_byte_t want;
		if (arst_n) begin
			in_taken <= push && !full;
			if (push && !full)
				encode_item(data_byte, byte_valid, end_of_article);
			if (wire_mode_we)
				enc_wire_mode = wire_mode_wdata;
			if (pop && !empty) begin
				if (wire_bytes_due.size() == 0) begin
					report_mismatch("unexpected out_byte", out_byte, 0);
				end else begin
					want = wire_bytes_due.pop_front();
					if (out_byte !== want.value)
						report_mismatch("out_byte", out_byte, want.value);
					if (out_last !== want.last)
						report_mismatch("out_last", out_last, want.last);
				end
			end
		end
	end

	// Sender: offers pending transactions in bursts with random gaps, or steadily when sender_steady is set.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken)
				pending_items.delete(0);
			if (!push || in_taken) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (pending_items.size() != 0) begin
					push <= 1'b1;
					data_byte <= pending_items[0].data;
					byte_valid <= pending_items[0].valid;
					end_of_article <= pending_items[0].eoa;
					if (burst_left > 0) begin
						burst_left--;
					end else if (!sender_steady) begin
						burst_left = $urandom_range(0, 15);
						gap_left = $urandom_range(1, 8);
					end
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Receiver: stalls on a rotating random pattern, or holds off for a long stretch.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				if (pat_left == 0) begin
					stall_pat = $urandom;
					if ($urandom_range(0, 3) == 0)
						stall_pat = '1;
					pat_left = 32;
				end
				pop <= stall_pat[0];
				stall_pat = {stall_pat[0], stall_pat[31:1]};
				pat_left--;
			end
		end
	end

	task automatic add_item(input logic [7:0] d, input logic v, input logic eoa);
		article_item_t it;
		it.data = d;
		it.valid = v;
		it.eoa = eoa;
		pending_items.push_back(it);
		if (v || eoa)
			items_queued++;
	endtask

	// Waits until everything sent has come out, then lets the block settle.
	task automatic wait_idle();
		while (pending_items.size() != 0 || push || wire_bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_wire_mode(input bit mode);
		wait_idle();
		@(negedge clk);
		wire_mode_we <= 1'b1;
		wire_mode_wdata <= mode;
		@(negedge clk);
		wire_mode_we <= 1'b0;
		@(posedge clk);
	endtask

	// Byte mix weighted toward the characters the encoder treats specially.
	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0, 1: b = CH_LF;
			2, 3: b = CH_DOT;
			4: b = CH_CR;
			default: b = 8'($urandom_range(0, 255));
		endcase
		return b;
	endfunction

	// One random article, in CR LF form with an occasional terminator when wire_form is set.
	task automatic queue_article(input bit wire_form);
		int len;
		int k;
		logic [7:0] b;
		len = $urandom_range(0, 9);
		for (k = 0; k < len; k++) begin
			b = pick_byte();
			if (wire_form && b == CH_LF && $urandom_range(0, 3) != 0)
				add_item(CH_CR, 1'b1, 1'b0);
			add_item(b, 1'b1, 1'b0);
			if ($urandom_range(0, 15) == 0)
				add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		end
		if (wire_form && $urandom_range(0, 2) == 0) begin
			add_item(CH_CR, 1'b1, 1'b0);
			add_item(CH_LF, 1'b1, 1'b0);
			add_item(CH_DOT, 1'b1, 1'b0);
			add_item(CH_CR, 1'b1, 1'b0);
			add_item(CH_LF, 1'b1, 1'b0);
		end
		if ($urandom_range(0, 1) == 0)
			add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		else
			add_item(pick_byte(), 1'b1, 1'b1);
	endtask

	// Stimulus: reset, directed articles, then random phases in both modes.
	initial begin
		int phase;
		int target;
		bit mode;
		clk = 1'b0;
		arst_n = 1'b0;
		wire_mode_we = 1'b0;
		wire_mode_wdata = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		data_byte = '0;
		byte_valid = 1'b0;
		end_of_article = 1'b0;
		in_taken = 1'b0;
		gap_left = 0;
		burst_left = 0;
		sender_steady = 1'b0;
		stall_pat = '1;
		pat_left = 0;
		hold_left = 0;
		hold_requests = 0;
		hold_served = 0;
		items_queued = 0;
		errors = 0;
		enc_wire_mode = MODE_LOCAL;
		enc_line_ended = 1'b0;
		enc_after_cr = 1'b0;
		enc_tail = '0;
		enc_tail_cnt = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Local text: leading dot kept, dot after LF doubled, idle item, empty final item.
		set_wire_mode(MODE_LOCAL);
		add_item(CH_DOT, 1'b1, 1'b0);
		add_item("a", 1'b1, 1'b0);
		add_item(CH_LF, 1'b1, 1'b0);
		add_item(CH_DOT, 1'b1, 1'b0);
		add_item("b", 1'b1, 1'b0);
		add_item(CH_LF, 1'b1, 1'b0);
		add_item(8'hFF, 1'b0, 1'b0);
		add_item(8'h00, 1'b0, 1'b1);
		// Byte extremes and a bare CR, ending without a line break.
		add_item(8'h00, 1'b1, 1'b0);
		add_item(CH_CR, 1'b1, 1'b0);
		add_item(8'hFF, 1'b1, 1'b1);
		// Stuffed dot on the final item gives the longest expansion.
		add_item(CH_LF, 1'b1, 1'b0);
		add_item(CH_DOT, 1'b1, 1'b1);
		// Empty article.
		add_item(8'hFF, 1'b0, 1'b1);

		// Wire form: already terminated, then a short article.
		set_wire_mode(MODE_WIRE);
		add_item("a", 1'b1, 1'b0);
		add_item(CH_CR, 1'b1, 1'b0);
		add_item(CH_LF, 1'b1, 1'b0);
		add_item(CH_DOT, 1'b1, 1'b0);
		add_item(CH_CR, 1'b1, 1'b0);
		add_item(CH_LF, 1'b1, 1'b0);
		add_item(8'h00, 1'b0, 1'b1);
		add_item(CH_DOT, 1'b1, 1'b0);
		add_item(CH_CR, 1'b1, 1'b0);
		add_item(CH_LF, 1'b1, 1'b1);

		// Mode change in the middle of an article.
		add_item("z", 1'b1, 1'b0);
		add_item(CH_CR, 1'b1, 1'b0);
		set_wire_mode(MODE_LOCAL);
		add_item(CH_LF, 1'b1, 1'b0);
		add_item(CH_DOT, 1'b1, 1'b1);

		// Random phases; one runs under a long receiver hold-off.
		for (phase = 0; phase < 6; phase++) begin
			if (phase < 2)
				mode = (phase == 0) ? MODE_WIRE : MODE_LOCAL;
			else
				mode = 1'($urandom_range(0, 1));
			set_wire_mode(mode);
			sender_steady = (phase == 2 || phase == 3);
			if (phase == 3)
				hold_requests++;
			target = items_queued + 15;
			while (items_queued < target)
				queue_article(mode);
		end

		wait_idle();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
